// ===== design/bctu_pkg.sv =====
// Shared types and constants for the bearer context table unit.
// Used by bctu_cell and bearer_context_table_unit; no dependencies.
package bctu_pkg;

  localparam int ID_W  = 4;
  localparam int CTX_W = 8;
  localparam int NST_W = 2;
  localparam int EVT_W = 3;

  // Request kinds, carried on in_tuser
  typedef enum logic [1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_SET     = 2'd2,
    CMD_GET     = 2'd3
  } cmd_t;

  // Request travelling down the row of cells, with what it picked up
  typedef struct packed {
    logic             vld;
    cmd_t             cmd;
    logic             in_range;   // bearer_id names an entry
    logic             auto_pick;  // assign with bearer_id 0
    logic [ID_W-1:0]  slot;       // target slot when not auto-picking
    logic [ID_W-1:0]  nsearch;    // next-fit start position
    logic [CTX_W-1:0] ctx;
    logic             dflt;
    logic [NST_W-1:0] nst;
    logic             term;
    // state of the target slot
    logic             hit_valid;
    logic             hit_active;
    logic             hit_dflt;
    logic [CTX_W-1:0] hit_ctx;
    // free-slot search: first free at/after start, first free before it
    logic             hi_found;
    logic [ID_W-1:0]  hi_slot;
    logic             lo_found;
    logic [ID_W-1:0]  lo_slot;
  } pkt_t;

  // Entry update broadcast to the cells when a request completes
  typedef struct packed {
    logic             we;
    logic [ID_W-1:0]  slot;
    logic             valid;
    logic             active;
    logic             set_data;   // also write default flag and context
    logic             dflt;
    logic [CTX_W-1:0] ctx;
  } wr_t;

endpackage

// ===== design/bctu_cell.sv =====
// One table entry of the bearer context table and its request stage.
// Depends on bctu_pkg.
module bctu_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,       // chain advances this cycle
  input  logic [bctu_pkg::ID_W-1:0]  cell_idx,  // slot number of this cell
  input  bctu_pkg::pkt_t             pkt_i,
  output bctu_pkg::pkt_t             pkt_o,
  input  bctu_pkg::wr_t              wr_i
);

  logic                       valid_r;
  logic                       active_r;
  logic                       dflt_r;
  logic [bctu_pkg::CTX_W-1:0] ctx_r;
  bctu_pkg::pkt_t             pkt_r;
  bctu_pkg::pkt_t             pkt_nxt;

  // Look at this entry as the request passes
  always_comb begin
    pkt_nxt = pkt_i;
    if (pkt_i.vld) begin
      if (!pkt_i.auto_pick && pkt_i.slot == cell_idx) begin
        pkt_nxt.hit_valid  = valid_r;
        pkt_nxt.hit_active = active_r;
        pkt_nxt.hit_dflt   = dflt_r;
        pkt_nxt.hit_ctx    = ctx_r;
      end
      if (!valid_r) begin
        if (cell_idx >= pkt_i.nsearch) begin
          if (!pkt_i.hi_found) begin
            pkt_nxt.hi_found = 1'b1;
            pkt_nxt.hi_slot  = cell_idx;
          end
        end else if (!pkt_i.lo_found) begin
          pkt_nxt.lo_found = 1'b1;
          pkt_nxt.lo_slot  = cell_idx;
        end
      end
    end
  end

  // Request stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= '0;
    end else if (adv) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

  // Entry status bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (wr_i.we && wr_i.slot == cell_idx) begin
      valid_r  <= wr_i.valid;
      active_r <= wr_i.active;
    end
  end

  // Entry payload, written on assign only
  always_ff @(posedge clk) begin
    if (wr_i.we && wr_i.set_data && wr_i.slot == cell_idx) begin
      dflt_r <= wr_i.dflt;
      ctx_r  <= wr_i.ctx;
    end
  end

endmodule

// ===== design/bearer_context_table_unit.sv =====
// Top level of the bearer context table: row of bctu_cell entries plus completion logic.
// Depends on bctu_pkg and bctu_cell.
//
// Usage:
//   Requests enter on the in_ channel (in_tuser = command, in_tdata = arguments),
//   one at a time. Each request walks the row of entry cells, one cell per cycle,
//   collecting the target entry and the next-fit free-slot candidates; after the
//   last cell the result is formed, the table is updated and one result is placed
//   on the out_ channel.
//   SPAN is the number of usable entries (11 by default). A new request is not
//   accepted until the current one has finished its walk through the cell row;
//   in_tready is low while a request walks.
//   A new request may be accepted while a finished result waits on out_.
//   If the receiver stalls with a result pending, the next request stops at the
//   end of the row until the output register frees up.
//   Reset (rst_n low, synchronous) clears all valid and active marks, the search
//   pointer and the output valid; default flags and context ids are written by assign.
module bearer_context_table_unit #(
  parameter int NUM_ENTRIES = 11,
  parameter int FIRST_ID    = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [15:0] in_tdata,   // [3:0] bearer_id, [11:4] context_id, [12] is_default,
                                  // [14:13] new_status, [15] by_terminal
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] ok, [4:1] assigned_id, [5] cur_status, [6] in_use,
                                  // [7] notify, [15:8] notify_context, [18:16] pdn_event
);

  localparam int ID_W = bctu_pkg::ID_W;
  localparam int SPAN = (NUM_ENTRIES < (1 << ID_W) - FIRST_ID) ?
                        NUM_ENTRIES : (1 << ID_W) - FIRST_ID;

  bctu_pkg::pkt_t       pkt_in;
  bctu_pkg::pkt_t       chain [SPAN+1];
  bctu_pkg::pkt_t       last_pkt;
  bctu_pkg::wr_t        wr;
  logic                 in_flight_r, in_flight_nxt;
  logic [ID_W-1:0]      next_search_r, next_search_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [23:0]          out_tdata_r, out_tdata_nxt;
  logic                 adv;
  logic                 finish;
  logic                 in_acc;
  logic [ID_W:0]        id_off;
  logic [ID_W-1:0]      bearer_id;

  // Results of the completed request
  logic                 r_ok;
  logic [ID_W-1:0]      r_assigned;
  logic                 r_cur;
  logic                 r_in_use;
  logic                 r_notify;
  logic [bctu_pkg::CTX_W-1:0] r_nctx;
  logic [bctu_pkg::EVT_W-1:0] r_event;
  logic [ID_W-1:0]      pick_slot;
  logic                 pick_ok;

  assign in_tready = !in_flight_r;
  assign in_acc    = in_tvalid && in_tready;
  assign last_pkt  = chain[SPAN];
  assign finish    = last_pkt.vld && (!out_tvalid_r || out_tready);
  assign adv       = !last_pkt.vld || finish;

  // Form the request that enters the first cell
  assign bearer_id = in_tdata[3:0];
  assign id_off    = {1'b0, bearer_id} - (ID_W+1)'(FIRST_ID);
  always_comb begin
    pkt_in           = '0;
    pkt_in.vld       = in_acc;
    pkt_in.cmd       = bctu_pkg::cmd_t'(in_tuser);
    pkt_in.in_range  = !id_off[ID_W] && (id_off < (ID_W+1)'(SPAN));
    pkt_in.auto_pick = (bctu_pkg::cmd_t'(in_tuser) == bctu_pkg::CMD_ASSIGN) &&
                       (bearer_id == '0);
    pkt_in.slot      = id_off[ID_W-1:0];
    pkt_in.nsearch   = next_search_r;
    pkt_in.ctx       = in_tdata[11:4];
    pkt_in.dflt      = in_tdata[12];
    pkt_in.nst       = in_tdata[14:13];
    pkt_in.term      = in_tdata[15];
  end

  assign chain[0] = pkt_in;

  // Row of entry cells
  for (genvar k = 0; k < SPAN; k++) begin : g_cell
    bctu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (ID_W'(k)),
      .pkt_i    (chain[k]),
      .pkt_o    (chain[k+1]),
      .wr_i     (wr)
    );
  end

  // Next-fit choice: first free at/after the pointer, else first free before it
  assign pick_ok   = last_pkt.hi_found || last_pkt.lo_found;
  assign pick_slot = last_pkt.hi_found ? last_pkt.hi_slot : last_pkt.lo_slot;

  // Complete the request: result fields and entry update
  always_comb begin
    r_ok       = 1'b0;
    r_assigned = '0;
    r_cur      = 1'b0;
    r_in_use   = 1'b0;
    r_notify   = 1'b0;
    r_nctx     = '0;
    r_event    = '0;
    wr         = '0;
    wr.dflt    = last_pkt.dflt;
    wr.ctx     = last_pkt.ctx;
    case (last_pkt.cmd)
      bctu_pkg::CMD_ASSIGN: begin
        if (last_pkt.auto_pick) begin
          r_ok    = pick_ok;
          wr.slot = pick_slot;
        end else begin
          r_ok    = last_pkt.in_range && !last_pkt.hit_valid;
          wr.slot = last_pkt.slot;
        end
        wr.we       = r_ok;
        wr.valid    = 1'b1;
        wr.active   = 1'b0;
        wr.set_data = 1'b1;
        if (r_ok) begin
          r_assigned = wr.slot + ID_W'(FIRST_ID);
        end
      end
      bctu_pkg::CMD_RELEASE: begin
        r_ok      = last_pkt.in_range && last_pkt.hit_valid && !last_pkt.hit_active;
        wr.we     = r_ok;
        wr.slot   = last_pkt.slot;
        wr.valid  = 1'b0;
        wr.active = 1'b0;
      end
      bctu_pkg::CMD_SET: begin
        r_ok      = last_pkt.in_range && last_pkt.hit_valid && !last_pkt.nst[1] &&
                    (last_pkt.nst[0] != last_pkt.hit_active);
        wr.we     = r_ok;
        wr.slot   = last_pkt.slot;
        wr.valid  = 1'b1;
        wr.active = last_pkt.nst[0];
        if (r_ok) begin
          r_notify = 1'b1;
          r_nctx   = last_pkt.hit_ctx;
          r_event  = {last_pkt.term, last_pkt.hit_dflt, last_pkt.nst[0]};
        end
      end
      bctu_pkg::CMD_GET: begin
        r_ok     = 1'b1;
        r_in_use = last_pkt.in_range && last_pkt.hit_valid;
        r_cur    = r_in_use && last_pkt.hit_active;
      end
      default: begin
        r_ok = 1'b0;
      end
    endcase
    wr.we = wr.we && finish;
  end

  // Control next values
  always_comb begin
    in_flight_nxt   = in_flight_r;
    next_search_nxt = next_search_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_tdata_nxt   = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (in_acc) begin
      in_flight_nxt = 1'b1;
    end
    if (finish) begin
      in_flight_nxt  = 1'b0;
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'd0, r_event, r_nctx, r_notify, r_in_use, r_cur, r_assigned, r_ok};
      if (wr.we && last_pkt.cmd == bctu_pkg::CMD_ASSIGN) begin
        next_search_nxt = wr.slot + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r   <= 1'b0;
      next_search_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      in_flight_r   <= in_flight_nxt;
      next_search_r <= next_search_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A completed request always leaves the flight flag clear and a result on out_
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> !in_flight_r && out_tvalid)
    else $error("request completed but block still busy or no result");

  // A request in the row implies the block is busy
  a_busy_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    last_pkt.vld |-> in_flight_r)
    else $error("request in cell row while not marked in flight");

  // Identity given out only on success, notification only on success
  a_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:1] != '0 || out_tdata[7]) |-> out_tdata[0])
    else $error("identity or notification on a failed request");

  // Search pointer moves only on a completed request
  a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(next_search_r))
    else $error("search pointer changed without a completed request");

endmodule

// ===== bench/tb_bearer_context_table_unit.sv =====
// Self-checking bench for bearer_context_table_unit: directed and random requests,
// each predicted against a shadow copy of the bearer table and checked per field.
// Depends on bctu_pkg and the design files of bearer_context_table_unit.
`timescale 1ns / 100ps

module tb_bearer_context_table_unit;

  localparam int NUM_ENTRIES    = 11;
  localparam int FIRST_ID       = 5;
  // usable identities end at 15
  localparam int SPAN           = (NUM_ENTRIES < 16 - FIRST_ID) ? NUM_ENTRIES : 16 - FIRST_ID;
  localparam int PHASE_ITEMS    = 125;
  localparam int NUM_PHASES     = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // Stall modes of the random phases
  localparam int MODE_STEADY  = 0;
  localparam int MODE_TX_IDLE = 1;
  localparam int MODE_RX_IDLE = 2;
  localparam int MODE_BOTH    = 3;

  // Request arguments as packed on in_tdata
  typedef struct packed {
    logic                       term;
    logic [bctu_pkg::NST_W-1:0] nst;
    logic                       dflt;
    logic [bctu_pkg::CTX_W-1:0] ctx;
    logic [bctu_pkg::ID_W-1:0]  bid;
  } req_args_t;

  typedef struct packed {
    bctu_pkg::cmd_t cmd;
    req_args_t      args;
  } bearer_req_t;

  // Result fields as packed on out_tdata
  typedef struct packed {
    logic [4:0]                 pad;
    logic [bctu_pkg::EVT_W-1:0] evt;
    logic [bctu_pkg::CTX_W-1:0] nctx;
    logic                       notify;
    logic                       in_use;
    logic                       cur_status;
    logic [bctu_pkg::ID_W-1:0]  aid;
    logic                       ok;
  } bearer_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // [1:0] cmd
  logic [15:0] in_tdata = '0;   // [3:0] bearer_id, [11:4] context_id, [12] is_default,
                                // [14:13] new_status, [15] by_terminal
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] ok, [4:1] assigned_id, [5] cur_status, [6] in_use,
                                // [7] notify, [15:8] notify_context, [18:16] pdn_event

  bearer_context_table_unit #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .FIRST_ID   (FIRST_ID)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the bearer table
  logic                       shadow_valid  [SPAN] = '{default: 1'b0};
  logic                       shadow_active [SPAN] = '{default: 1'b0};
  logic                       shadow_dflt   [SPAN] = '{default: 1'b0};
  logic [bctu_pkg::CTX_W-1:0] shadow_ctx    [SPAN] = '{default: '0};
  logic [bctu_pkg::ID_W-1:0]  shadow_next = '0;

  bearer_req_t  req_backlog[$];
  bearer_resp_t pending_results[$];
  bearer_req_t  driven_req;
  int           stall_mode = MODE_STEADY;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  function automatic int slot_of_id(logic [bctu_pkg::ID_W-1:0] id);
    if (int'(id) < FIRST_ID || int'(id) - FIRST_ID >= SPAN) return -1;
    return int'(id) - FIRST_ID;
  endfunction

  // Next-fit search from the pointer, then one wrap from slot 0
  function automatic int find_free_slot();
    int start;
    start = int'(shadow_next);
    for (int k = start; k < SPAN; k++)
      if (!shadow_valid[k]) return k;
    for (int k = 0; k < start && k < SPAN; k++)
      if (!shadow_valid[k]) return k;
    return -1;
  endfunction

  // Applies one request to the shadow table and returns its result
  function automatic bearer_resp_t table_predict(bearer_req_t r);
    bearer_resp_t res;
    int           s;
    res = '0;
    s = slot_of_id(r.args.bid);
    case (r.cmd)
      bctu_pkg::CMD_ASSIGN: begin
        if (r.args.bid == '0) s = find_free_slot();
        else if (s >= 0 && shadow_valid[s]) s = -1;
        if (s >= 0) begin
          shadow_valid[s]  = 1'b1;
          shadow_active[s] = 1'b0;
          shadow_dflt[s]   = r.args.dflt;
          shadow_ctx[s]    = r.args.ctx;
          shadow_next      = bctu_pkg::ID_W'(s + 1);
          res.ok  = 1'b1;
          res.aid = bctu_pkg::ID_W'(s + FIRST_ID);
        end
      end
      bctu_pkg::CMD_RELEASE: begin
        if (s >= 0 && shadow_valid[s] && !shadow_active[s]) begin
          shadow_valid[s] = 1'b0;
          res.ok = 1'b1;
        end
      end
      bctu_pkg::CMD_SET: begin
        // invalid or unchanged status is refused without notification
        if (s >= 0 && shadow_valid[s] && r.args.nst <= 2'd1 &&
            r.args.nst[0] != shadow_active[s]) begin
          shadow_active[s] = r.args.nst[0];
          res.ok     = 1'b1;
          res.notify = 1'b1;
          res.nctx   = shadow_ctx[s];
          res.evt    = {r.args.term, shadow_dflt[s], r.args.nst[0]};
        end
      end
      default: begin
        res.ok = 1'b1;
        if (s >= 0 && shadow_valid[s]) begin
          res.cur_status = shadow_active[s];
          res.in_use     = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  task automatic add_req(bctu_pkg::cmd_t cmd, int id, int ctx, bit dflt, int nst, bit term);
    bearer_req_t r;
    r.cmd       = cmd;
    r.args.bid  = bctu_pkg::ID_W'(id);
    r.args.ctx  = bctu_pkg::CTX_W'(ctx);
    r.args.dflt = dflt;
    r.args.nst  = bctu_pkg::NST_W'(nst);
    r.args.term = term;
    req_backlog.push_back(r);
  endtask

  // Mostly in-range identities and valid statuses, so entries cycle through
  // assign, activate, deactivate and release; the rest is noise.
  task automatic add_random_req();
    int             roll;
    int             id;
    int             nst;
    bctu_pkg::cmd_t cmd;
    roll = $urandom_range(99, 0);
    if (roll < 30) cmd = bctu_pkg::CMD_ASSIGN;
    else if (roll < 55) cmd = bctu_pkg::CMD_RELEASE;
    else if (roll < 85) cmd = bctu_pkg::CMD_SET;
    else cmd = bctu_pkg::CMD_GET;
    roll = $urandom_range(99, 0);
    if (roll < 65) id = $urandom_range(15, FIRST_ID);
    else if (roll < 80 && cmd == bctu_pkg::CMD_ASSIGN) id = 0;
    else id = $urandom_range(15, 0);
    nst = ($urandom_range(99, 0) < 85) ? $urandom_range(1, 0) : $urandom_range(3, 2);
    add_req(cmd, id, $urandom_range(255, 0), 1'($urandom_range(1, 0)), nst,
            1'($urandom_range(1, 0)));
  endtask

  function automatic bit idle_roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int tx_idle_pct(int mode);
    if (mode == MODE_TX_IDLE) return 67;
    if (mode == MODE_BOTH) return 17;
    return 0;
  endfunction

  function automatic int rx_idle_pct(int mode);
    if (mode == MODE_RX_IDLE) return 67;
    if (mode == MODE_BOTH) return 17;
    return 0;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Request driver: predict on acceptance, then present the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pending_results.push_back(table_predict(driven_req));
      if (!in_tvalid || in_tready) begin
        if (req_backlog.size() > 0 && !idle_roll(tx_idle_pct(stall_mode))) begin
          driven_req = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= driven_req.cmd;
          in_tdata  <= driven_req.args;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    bearer_resp_t exp_res;
    bearer_resp_t act_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        act_res = out_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t ERROR unexpected result: got 0x%0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("ok", 32'(exp_res.ok), 32'(act_res.ok));
          check_field("assigned_id", 32'(exp_res.aid), 32'(act_res.aid));
          check_field("cur_status", 32'(exp_res.cur_status), 32'(act_res.cur_status));
          check_field("in_use", 32'(exp_res.in_use), 32'(act_res.in_use));
          check_field("notify", 32'(exp_res.notify), 32'(act_res.notify));
          check_field("notify_context", 32'(exp_res.nctx), 32'(act_res.nctx));
          check_field("pdn_event", 32'(exp_res.evt), 32'(act_res.evt));
          check_field("unused bits", 32'(exp_res.pad), 32'(act_res.pad));
        end
      end
      out_tready <= !idle_roll(rx_idle_pct(stall_mode));
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus sequencing
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: out-of-range and unassigned identities
    add_req(bctu_pkg::CMD_GET, 0, 0, 0, 0, 0);
    add_req(bctu_pkg::CMD_GET, 4, 0, 0, 0, 0);
    add_req(bctu_pkg::CMD_ASSIGN, 4, 8'h5a, 1, 0, 0);
    add_req(bctu_pkg::CMD_RELEASE, 5, 0, 0, 0, 0);
    add_req(bctu_pkg::CMD_SET, 5, 0, 0, 1, 0);
    // auto-pick into the first slot, explicit assign of the top identity
    add_req(bctu_pkg::CMD_ASSIGN, 0, 8'hff, 1, 0, 0);
    add_req(bctu_pkg::CMD_ASSIGN, 15, 8'h00, 1, 0, 0);
    add_req(bctu_pkg::CMD_ASSIGN, 15, 8'h33, 0, 0, 0);
    // invalid and unchanged status are refused
    add_req(bctu_pkg::CMD_SET, 15, 0, 0, 2, 1);
    add_req(bctu_pkg::CMD_SET, 15, 0, 0, 3, 0);
    add_req(bctu_pkg::CMD_SET, 15, 0, 0, 0, 0);
    // network activation of a default bearer gives event code 3
    add_req(bctu_pkg::CMD_SET, 15, 0, 0, 1, 0);
    add_req(bctu_pkg::CMD_RELEASE, 15, 0, 0, 0, 0);
    add_req(bctu_pkg::CMD_GET, 15, 0, 0, 0, 0);
    add_req(bctu_pkg::CMD_SET, 15, 0, 0, 0, 1);
    add_req(bctu_pkg::CMD_RELEASE, 15, 0, 0, 0, 0);
    // pointer now past the table: search wraps, then fill until full
    for (int i = 0; i <= SPAN - 1; i++)
      add_req(bctu_pkg::CMD_ASSIGN, 0, $urandom_range(255, 0), 1'($urandom_range(1, 0)),
              0, 0);

    // Random phases, cycling through the stall modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      while (req_backlog.size() != 0 || in_tvalid || pending_results.size() != 0)
        @(negedge clk);
      stall_mode = p % 4;
      for (int i = 0; i < PHASE_ITEMS; i++) add_random_req();
    end

    while (req_backlog.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (2 * (SPAN + 1) + 4) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
